// ===== design/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants of the box filter resampler
// Sizes, queue entry layout, configuration bundle and register indexes.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int MAX_SIDE     = 512;
  localparam int MAX_CHANNELS = 4;
  localparam int SIDE_W       = $clog2(MAX_SIDE + 1);
  localparam int COORD_W      = 9;
  localparam int CH_W         = 2;
  localparam int NC_W         = $clog2(MAX_CHANNELS + 1);
  localparam int VAL_W        = 8;
  localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int MUL_W        = 2 * SIDE_W;
  localparam int PROD_W       = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int PITCH_W      = SIDE_W + NC_W;
  localparam int COUNT_W      = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SUM_W        = COUNT_W + VAL_W;
  localparam int DIVN_W       = SUM_W;
  localparam int DIVD_W       = COUNT_W;
  localparam int DCNT_W       = $clog2(DIVN_W + 1);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int CIDX_W       = 3;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_TGT_W = 3'd2,
    REG_TGT_H = 3'd3,
    REG_CHANS = 3'd4
  } reg_idx_t;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    K_WRITE  = 2'd0,
    K_SAMPLE = 2'd1,
    K_ERROR  = 2'd2
  } kind_t;

  // Effective (clamped) geometry.
  typedef struct packed {
    logic [SIDE_W-1:0] sw;
    logic [SIDE_W-1:0] sh;
    logic [SIDE_W-1:0] tw;
    logic [SIDE_W-1:0] th;
    logic [NC_W-1:0]   nc;
  } cfg_t;

  // One queued request: a write uses x0/y0/value, a sample the whole rectangle.
  typedef struct packed {
    kind_t             kind;
    logic [SIDE_W-1:0] x0;
    logic [SIDE_W-1:0] x1;
    logic [SIDE_W-1:0] y0;
    logic [SIDE_W-1:0] y1;
    logic [CH_W-1:0]   ch;
    logic [VAL_W-1:0]  value;
  } qent_t;

  // Sizes of zero act as one, oversize values as the maximum.
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  function automatic logic [NC_W-1:0] eff_chans(input logic [NC_W-1:0] v);
    logic [NC_W-1:0] r;
    r = v;
    if (v == '0) r = NC_W'(1);
    else if (v > NC_W'(MAX_CHANNELS)) r = NC_W'(MAX_CHANNELS);
    return r;
  endfunction

endpackage

// ===== design/box_filter_resampler_unit.sv =====
// ----------------------------------------------------------------------------
// box_filter_resampler_unit: area-average image resampler
// Stores an interleaved source image and returns box-filtered output pixels.
//
//   Channel  Ports                                        Request
//   input    in_push / in_full, in_cmd..in_write_value    write byte or sample
//   result   out_empty / out_pop, out_average, out_range_error  one per sample
//   config   cfg_we, cfg_index, cfg_data                  register write
//
// In the front, a sample runs four serial divisions for the span bounds on
// one divider, while the back sums the rectangle at one texel per cycle from
// the store's read port and then divides the sum in its own divider.
// Reset is synchronous; the store itself is not cleared.
// A four-entry queue lets the front compute the next span while the back
// still sums, and a one-entry result register holds a result until popped.
// ----------------------------------------------------------------------------
module box_filter_resampler_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfr_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bfr_pkg::SIDE_W-1:0]  cfg_data,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic [bfr_pkg::COORD_W-1:0] in_col,
  input  logic [bfr_pkg::COORD_W-1:0] in_row,
  input  logic [bfr_pkg::CH_W-1:0]    in_channel,
  input  logic [bfr_pkg::VAL_W-1:0]   in_write_value,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [bfr_pkg::VAL_W-1:0]   out_average,
  output logic                        out_range_error
);
  import bfr_pkg::*;

  logic [SIDE_W-1:0] sw_r, sh_r, tw_r, th_r;
  logic [NC_W-1:0]   nc_r;
  cfg_t              cfg;
  logic              q_push, q_full, q_pop, q_empty;
  qent_t             q_in, q_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SIDE_W'(128);
      sh_r <= SIDE_W'(128);
      tw_r <= SIDE_W'(64);
      th_r <= SIDE_W'(64);
      nc_r <= NC_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W: sw_r <= cfg_data;
        REG_SRC_H: sh_r <= cfg_data;
        REG_TGT_W: tw_r <= cfg_data;
        REG_TGT_H: th_r <= cfg_data;
        REG_CHANS: nc_r <= cfg_data[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry seen by both halves.
  assign cfg.sw = eff_side(sw_r);
  assign cfg.sh = eff_side(sh_r);
  assign cfg.tw = eff_side(tw_r);
  assign cfg.th = eff_side(th_r);
  assign cfg.nc = eff_chans(nc_r);

  bfr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_channel     (in_channel),
    .in_write_value (in_write_value),
    .q_push         (q_push),
    .q_data         (q_in),
    .q_full         (q_full)
  );

  bfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  bfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_average     (out_average),
    .out_range_error (out_range_error)
  );
endmodule

// ===== design/bfr_div.sv =====
// ----------------------------------------------------------------------------
// bfr_div: restoring divider, one quotient bit per cycle
// Unsigned DIVN_W by DIVD_W bits; done pulses when quotient and rest are ready.
// ----------------------------------------------------------------------------
module bfr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bfr_pkg::DIVN_W-1:0]  dividend,
  input  logic [bfr_pkg::DIVD_W-1:0]  divisor,
  output logic                        done,
  output logic [bfr_pkg::DIVN_W-1:0]  quotient,
  output logic [bfr_pkg::DIVD_W-1:0]  remainder
);
  import bfr_pkg::*;

  logic [DIVD_W-1:0] rem_r;
  logic [DIVN_W-1:0] quo_r;
  logic [DIVD_W-1:0] dsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVD_W:0]   shifted;
  logic              fits;

  // Shift in the next dividend bit and try to subtract.
  assign shifted = {rem_r, quo_r[DIVN_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVN_W-2:0], fits};
      rem_r <= fits ? DIVD_W'(shifted - {1'b0, dsr_r}) : DIVD_W'(shifted);
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

// ===== design/bfr_queue.sv =====
// ----------------------------------------------------------------------------
// bfr_queue: small request queue between front and back
// QDEPTH entries of qent_t, first in first out.
// ----------------------------------------------------------------------------
module bfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bfr_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output bfr_pkg::qent_t pop_data,
  output logic           empty
);
  import bfr_pkg::*;

  qent_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign full    = cnt_r == (QPTR_W + 1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + QPTR_W'(1);
      if (do_pop)  rp_r <= rp_r + QPTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (QPTR_W + 1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (QPTR_W + 1)'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_data;
  end

  assign pop_data = slot_r[rp_r];
endmodule

// ===== design/bfr_front.sv =====
// ----------------------------------------------------------------------------
// bfr_front: request intake and rectangle computation
// Checks ranges, drops bad writes, and computes the covered source span of a
// sample with four exact divisions on one shared divider.
// ----------------------------------------------------------------------------
module bfr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfr_pkg::cfg_t               cfg,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic [bfr_pkg::COORD_W-1:0] in_col,
  input  logic [bfr_pkg::COORD_W-1:0] in_row,
  input  logic [bfr_pkg::CH_W-1:0]    in_channel,
  input  logic [bfr_pkg::VAL_W-1:0]   in_write_value,
  output logic                        q_push,
  output bfr_pkg::qent_t              q_data,
  input  logic                        q_full
);
  import bfr_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_DIV  = 5'b00100,
    F_WAIT = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t              state_r, state_nxt;
  qent_t                ent_r;
  logic [COORD_W-1:0]   col_r, row_r;
  logic [1:0]           step_r;
  logic [DIVN_W-1:0]    dvn_r;
  logic [DIVD_W-1:0]    dvd_r;
  logic                 accept;
  logic                 wr_ok, smp_err;
  logic [SIDE_W-1:0]    oper, s_sel, t_sel, lo_sel;
  logic                 div_done;
  logic [DIVN_W-1:0]    div_q;
  logic [DIVD_W-1:0]    div_r;
  logic [DIVN_W-1:0]    up_q;
  logic [SIDE_W-1:0]    lo_val, hi_val;

  assign in_full = state_r != F_IDLE;
  assign accept  = in_push && (state_r == F_IDLE);
  assign q_push  = state_r == F_PUSH;
  assign q_data  = ent_r;

  // Range checks against the effective geometry.
  assign wr_ok   = (SIDE_W'(in_col) < cfg.sw) && (SIDE_W'(in_row) < cfg.sh) &&
                   (NC_W'(in_channel) < cfg.nc);
  assign smp_err = (SIDE_W'(in_col) >= cfg.tw) || (SIDE_W'(in_row) >= cfg.th) ||
                   (NC_W'(in_channel) >= cfg.nc);

  // Step bit 1 picks the axis, bit 0 the upper bound (o + 1).
  assign oper   = (step_r[1] ? SIDE_W'(row_r) : SIDE_W'(col_r)) + SIDE_W'(step_r[0]);
  assign s_sel  = step_r[1] ? cfg.sh : cfg.sw;
  assign t_sel  = step_r[1] ? cfg.th : cfg.tw;
  assign lo_sel = step_r[1] ? ent_r.y0 : ent_r.x0;

  // Clamp the floor bound below the size and round the ceiling bound up.
  always_comb begin
    up_q   = div_q + DIVN_W'(div_r != '0);
    lo_val = (div_q > DIVN_W'(s_sel - SIDE_W'(1))) ? s_sel - SIDE_W'(1) : SIDE_W'(div_q);
    hi_val = (up_q > DIVN_W'(s_sel)) ? s_sel : SIDE_W'(up_q);
    if (hi_val < lo_sel + SIDE_W'(1)) hi_val = lo_sel + SIDE_W'(1);
  end

  bfr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == F_DIV),
    .dividend  (dvn_r),
    .divisor   (dvd_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Control sequence.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (!in_cmd) state_nxt = wr_ok ? F_PUSH : F_IDLE;
          else state_nxt = smp_err ? F_PUSH : F_MUL;
        end
      end
      F_MUL:  state_nxt = F_DIV;
      F_DIV:  state_nxt = F_WAIT;
      F_WAIT: begin
        if (div_done) state_nxt = (step_r == 2'b11) ? F_PUSH : F_MUL;
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) step_r <= '0;
      else if (state_r == F_WAIT && div_done) step_r <= step_r + 2'd1;
    end
  end

  // Request fields and division operands.
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r       <= in_col;
      row_r       <= in_row;
      ent_r.ch    <= in_channel;
      ent_r.value <= in_write_value;
      ent_r.x0    <= SIDE_W'(in_col);
      ent_r.y0    <= SIDE_W'(in_row);
      ent_r.x1    <= '0;
      ent_r.y1    <= '0;
      if (!in_cmd) ent_r.kind <= K_WRITE;
      else ent_r.kind <= smp_err ? K_ERROR : K_SAMPLE;
    end
    if (state_r == F_MUL) begin
      dvn_r <= DIVN_W'(MUL_W'(oper) * MUL_W'(s_sel));
      dvd_r <= DIVD_W'(t_sel);
    end
    if (state_r == F_WAIT && div_done) begin
      case (step_r)
        2'b00:   ent_r.x0 <= lo_val;
        2'b01:   ent_r.x1 <= hi_val;
        2'b10:   ent_r.y0 <= lo_val;
        default: ent_r.y1 <= hi_val;
      endcase
    end
  end
endmodule

// ===== design/bfr_back.sv =====
// ----------------------------------------------------------------------------
// bfr_back: source store and averaging engine
// Executes queued writes, sums a sample's rectangle one texel per cycle and
// divides by the texel count; holds one finished result for the consumer.
// ----------------------------------------------------------------------------
module bfr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bfr_pkg::cfg_t             cfg,
  input  logic                      q_empty,
  input  bfr_pkg::qent_t            q_data,
  output logic                      q_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [bfr_pkg::VAL_W-1:0] out_average,
  output logic                      out_range_error
);
  import bfr_pkg::*;

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_ADDR  = 9'b000000010,
    B_BASE  = 9'b000000100,
    B_WRITE = 9'b000001000,
    B_READ  = 9'b000010000,
    B_DRAIN = 9'b000100000,
    B_DIV   = 9'b001000000,
    B_WAIT  = 9'b010000000,
    B_OUT   = 9'b100000000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  qent_t              ent_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ADDR_W-1:0]  addr_r, row_addr_r, base_addr;
  logic [PITCH_W-1:0] pitch_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SIDE_W-1:0]  xc_r, yc_r;
  logic [VAL_W-1:0]   mem [STORE_DEPTH];
  logic [VAL_W-1:0]   rd_data_r;
  logic               rd_vld_r;
  logic [VAL_W-1:0]   res_avg_r, out_avg_r;
  logic               res_err_r, out_err_r;
  logic               out_vld_r;
  logic               x_end, last, slot_free;
  logic               div_done;
  logic [DIVN_W-1:0]  div_q;
  logic [DIVD_W-1:0]  div_r;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign x_end     = xc_r == ent_r.x1 - SIDE_W'(1);
  assign last      = x_end && (yc_r == ent_r.y1 - SIDE_W'(1));
  assign slot_free = !out_vld_r || out_pop;
  assign base_addr = ADDR_W'(ADDR_W'(prod_r) * ADDR_W'(cfg.nc) + ADDR_W'(ent_r.ch));

  bfr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == B_DIV),
    .dividend  (sum_r),
    .divisor   (cnt_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Control sequence.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = (q_data.kind == K_ERROR) ? B_OUT : B_ADDR;
      end
      B_ADDR:  state_nxt = B_BASE;
      B_BASE:  state_nxt = (ent_r.kind == K_WRITE) ? B_WRITE : B_READ;
      B_WRITE: state_nxt = B_IDLE;
      B_READ: begin
        if (last) state_nxt = B_DRAIN;
      end
      B_DRAIN: state_nxt = B_DIV;
      B_DIV:   state_nxt = B_WAIT;
      B_WAIT: begin
        if (div_done) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (slot_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control registers and the output slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= state_r == B_READ;
      if (state_r == B_OUT && slot_free) out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;
    end
  end

  // Address walk, accumulation and result capture.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r     <= q_data;
      res_avg_r <= '0;
      res_err_r <= 1'b1;
    end
    if (state_r == B_ADDR) begin
      prod_r <= PROD_W'(MUL_W'(ent_r.y0) * MUL_W'(cfg.sw) + MUL_W'(ent_r.x0));
    end
    if (state_r == B_BASE) begin
      addr_r     <= base_addr;
      row_addr_r <= base_addr;
      pitch_r    <= PITCH_W'(PITCH_W'(cfg.sw) * PITCH_W'(cfg.nc));
      cnt_r      <= COUNT_W'(MUL_W'(ent_r.x1 - ent_r.x0) * MUL_W'(ent_r.y1 - ent_r.y0));
      xc_r       <= ent_r.x0;
      yc_r       <= ent_r.y0;
      sum_r      <= '0;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
    end
    if (state_r == B_READ) begin
      if (x_end) begin
        xc_r       <= ent_r.x0;
        yc_r       <= yc_r + SIDE_W'(1);
        row_addr_r <= row_addr_r + ADDR_W'(pitch_r);
        addr_r     <= row_addr_r + ADDR_W'(pitch_r);
      end else begin
        xc_r   <= xc_r + SIDE_W'(1);
        addr_r <= addr_r + ADDR_W'(cfg.nc);
      end
    end
    if (state_r == B_WAIT && div_done) begin
      res_avg_r <= div_q[VAL_W-1:0];
      res_err_r <= 1'b0;
    end
    if (state_r == B_OUT && slot_free) begin
      out_avg_r <= res_avg_r;
      out_err_r <= res_err_r;
    end
  end

  // Source store: at most one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state_r == B_WRITE) mem[addr_r] <= ent_r.value;
    rd_data_r <= mem[addr_r];
  end

  assign out_empty       = !out_vld_r;
  assign out_average     = out_avg_r;
  assign out_range_error = out_err_r;
endmodule

// ===== bench/box_filter_resampler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// box_filter_resampler_unit_tb: self-checking bench for the box resampler
// Loads source bytes, samples output pixels under several geometries and
// compares every result with a scoreboard that averages its own copy of the
// source store. Both channels idle in random bursts; the last phase does not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_resampler_unit_tb;
  import bfr_pkg::*;

  localparam bit CMD_WRITE  = 1'b0;
  localparam bit CMD_SAMPLE = 1'b1;
  localparam int AREA_LIMIT = 100;

  // Scoreboard: holds the source bytes, the registers and the pending pixels.
  class resample_scoreboard;
    typedef struct {
      logic [VAL_W-1:0] average;
      logic             range_error;
    } pixel_t;

    int src_w, src_h, tgt_w, tgt_h, chans;
    byte unsigned texel_mem[int];
    pixel_t pending_pixels[$];
    int mismatches;

    function new();
      src_w = 128;
      src_h = 128;
      tgt_w = 64;
      tgt_h = 64;
      chans = 4;
      mismatches = 0;
    endfunction

    function int eff_side_of(int v);
      if (v < 1) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
    endfunction

    function int eff_chans_of(int v);
      if (v < 1) return 1;
      if (v > MAX_CHANNELS) return MAX_CHANNELS;
      return v;
    endfunction

    // Exact covered span of output index o for source size s, target size t.
    function void cover_span(int o, int s, int t, output int lo, output int hi);
      int num;
      lo = (o * s) / t;
      num = (o + 1) * s;
      hi = num / t + ((num % t) != 0 ? 1 : 0);
      if (lo > s - 1) lo = s - 1;
      if (hi > s) hi = s;
      if (hi < lo + 1) hi = lo + 1;
    endfunction

    function int texel_addr(int x, int y, int ch);
      return (y * eff_side_of(src_w) + x) * eff_chans_of(chans) + ch;
    endfunction

    function void set_reg(reg_idx_t idx, int v);
      case (idx)
        REG_SRC_W: src_w = v & 'h3FF;
        REG_SRC_H: src_h = v & 'h3FF;
        REG_TGT_W: tgt_w = v & 'h3FF;
        REG_TGT_H: tgt_h = v & 'h3FF;
        REG_CHANS: chans = v & 'h7;
        default: ;
      endcase
    endfunction

    function bit sample_out_of_range(int col, int row, int ch);
      return col >= eff_side_of(tgt_w) || row >= eff_side_of(tgt_h) ||
             ch >= eff_chans_of(chans);
    endfunction

    // A sample may be sent when it errors out or covers only written bytes.
    function bit sample_allowed(int col, int row, int ch);
      int x0, x1, y0, y1;
      if (sample_out_of_range(col, row, ch)) return 1;
      cover_span(col, eff_side_of(src_w), eff_side_of(tgt_w), x0, x1);
      cover_span(row, eff_side_of(src_h), eff_side_of(tgt_h), y0, y1);
      if ((x1 - x0) * (y1 - y0) > AREA_LIMIT) return 0;
      for (int y = y0; y < y1; y++)
        for (int x = x0; x < x1; x++)
          if (!texel_mem.exists(texel_addr(x, y, ch))) return 0;
      return 1;
    endfunction

    // Apply one accepted request; a sample queues its expected pixel.
    function void note_request(bit cmd, int col, int row, int ch, int val);
      pixel_t px;
      int x0, x1, y0, y1, sum, count;
      if (cmd == CMD_WRITE) begin
        if (col < eff_side_of(src_w) && row < eff_side_of(src_h) &&
            ch < eff_chans_of(chans))
          texel_mem[texel_addr(col, row, ch)] = 8'(val);
        return;
      end
      px.average = '0;
      px.range_error = 1'b1;
      if (!sample_out_of_range(col, row, ch)) begin
        cover_span(col, eff_side_of(src_w), eff_side_of(tgt_w), x0, x1);
        cover_span(row, eff_side_of(src_h), eff_side_of(tgt_h), y0, y1);
        sum = 0;
        count = 0;
        for (int y = y0; y < y1; y++)
          for (int x = x0; x < x1; x++) begin
            if (texel_mem.exists(texel_addr(x, y, ch))) sum += texel_mem[texel_addr(x, y, ch)];
            count++;
          end
        px.average = VAL_W'(sum / count);
        px.range_error = 1'b0;
      end
      pending_pixels.push_back(px);
    endfunction

    function void check_result(logic [VAL_W-1:0] average, logic range_error);
      pixel_t px;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: average=%0d range_error=%0b", average, range_error);
        return;
      end
      px = pending_pixels.pop_front();
      if (average !== px.average || range_error !== px.range_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected average=%0d range_error=%0b, got %0d %0b",
                   px.average, px.range_error, average, range_error);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CIDX_W-1:0]     cfg_index;
  logic [SIDE_W-1:0]     cfg_data;
  logic                  in_push;
  logic                  in_full;
  logic                  in_cmd;
  logic [COORD_W-1:0]    in_col;
  logic [COORD_W-1:0]    in_row;
  logic [CH_W-1:0]       in_channel;
  logic [VAL_W-1:0]      in_write_value;
  logic                  out_empty;
  logic                  out_pop;
  logic [VAL_W-1:0]      out_average;
  logic                  out_range_error;

  resample_scoreboard sb;
  bit quiet;

  box_filter_resampler_unit i_dut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #50ms;
    $display("box_filter_resampler_unit_tb: FAIL");
    $finish;
  end

  // Send one request, with an optional idle burst ahead of it.
  task automatic push_request(bit cmd, int col, int row, int ch, int val);
    if (!quiet && $urandom_range(3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_col <= COORD_W'(col);
    in_row <= COORD_W'(row);
    in_channel <= CH_W'(ch);
    in_write_value <= VAL_W'(val);
    do @(posedge clk); while (in_full);
    sb.note_request(cmd, col, row, ch, val);
  endtask

  // Drain all results, let trailing writes settle, then write every register.
  task automatic load_geometry(int sw, int sh, int tw, int th, int nc);
    in_push <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      int v;
      v = (i == 0) ? sw : (i == 1) ? sh : (i == 2) ? tw : (i == 3) ? th : nc;
      cfg_we <= 1'b1;
      cfg_index <= CIDX_W'(i);
      cfg_data <= SIDE_W'(v);
      @(posedge clk);
      sb.set_reg(reg_idx_t'(i), v);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly fill-then-sample sequences, the rest noise.
  task automatic run_phase(int n);
    int cnt, pick, col, row, ch, sw, sh, tw, th, nc, x0, x1, y0, y1;
    cnt = 0;
    sw = sb.eff_side_of(sb.src_w);
    sh = sb.eff_side_of(sb.src_h);
    tw = sb.eff_side_of(sb.tgt_w);
    th = sb.eff_side_of(sb.tgt_h);
    nc = sb.eff_chans_of(sb.chans);
    while (cnt < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        col = $urandom_range(tw - 1);
        row = $urandom_range(th - 1);
        ch = $urandom_range(nc - 1);
        sb.cover_span(col, sw, tw, x0, x1);
        sb.cover_span(row, sh, th, y0, y1);
        if ((x1 - x0) * (y1 - y0) <= AREA_LIMIT) begin
          for (int y = y0; y < y1; y++)
            for (int x = x0; x < x1; x++)
              if (!sb.texel_mem.exists(sb.texel_addr(x, y, ch)) || $urandom_range(3) == 0) begin
                push_request(CMD_WRITE, x, y, ch, $urandom_range(255));
                cnt++;
              end
          push_request(CMD_SAMPLE, col, row, ch, $urandom_range(255));
          cnt++;
        end
      end else if (pick < 85) begin
        push_request(CMD_WRITE, $urandom_range(511), $urandom_range(511),
                     $urandom_range(3), $urandom_range(255));
        cnt++;
      end else begin
        col = $urandom_range(511);
        row = $urandom_range(511);
        ch = $urandom_range(3);
        if (sb.sample_allowed(col, row, ch)) begin
          push_request(CMD_SAMPLE, col, row, ch, $urandom_range(255));
          cnt++;
        end
      end
    end
  endtask

  // Result side: pop with random stall bursts and check each accepted pixel.
  initial begin
    int stall;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_average, out_range_error);
      if (stall > 0) begin
        stall--;
      end else if (!quiet && $urandom_range(5) == 0) begin
        stall = $urandom_range(1, 18);
      end
      out_pop <= (stall == 0);
    end
  end

  // Stimulus.
  initial begin
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_cmd = CMD_WRITE;
    in_col = '0;
    in_row = '0;
    in_channel = '0;
    in_write_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 2x2 single-channel source squeezed to one pixel.
    load_geometry(2, 2, 1, 1, 1);
    push_request(CMD_WRITE, 0, 0, 0, 0);
    push_request(CMD_WRITE, 1, 0, 0, 255);
    push_request(CMD_WRITE, 0, 1, 0, 255);
    push_request(CMD_WRITE, 1, 1, 0, 255);
    // Writes outside the source are ignored.
    push_request(CMD_WRITE, 511, 0, 0, 7);
    push_request(CMD_WRITE, 0, 511, 0, 7);
    push_request(CMD_WRITE, 0, 0, 3, 7);
    push_request(CMD_SAMPLE, 0, 0, 0, 255);
    // Samples outside the target or the channel count flag an error.
    push_request(CMD_SAMPLE, 1, 0, 0, 0);
    push_request(CMD_SAMPLE, 0, 511, 0, 0);
    push_request(CMD_SAMPLE, 0, 0, 3, 0);
    push_request(CMD_SAMPLE, 511, 511, 3, 0);
    // Zero sizes act as one; oversize values clamp to the maximum.
    load_geometry(0, 0, 0, 0, 0);
    push_request(CMD_SAMPLE, 0, 0, 0, 0);
    push_request(CMD_SAMPLE, 0, 0, 1, 0);
    load_geometry(1023, 1023, 1023, 1023, 7);
    push_request(CMD_WRITE, 511, 511, 3, 200);
    push_request(CMD_SAMPLE, 511, 511, 3, 0);
    push_request(CMD_WRITE, 0, 0, 3, 1);
    push_request(CMD_SAMPLE, 0, 0, 3, 0);

    // Random phases over a range of geometries.
    load_geometry(128, 128, 64, 64, 4);
    run_phase(150);
    load_geometry(512, 1, 512, 1, 4);
    run_phase(150);
    load_geometry(1, 1, 512, 512, 1);
    run_phase(130);
    load_geometry(7, 5, 3, 2, 3);
    run_phase(150);
    load_geometry(5, 3, 9, 7, 2);
    run_phase(150);
    load_geometry(512, 512, 64, 64, 2);
    run_phase(150);
    load_geometry(40, 33, 5, 4, 4);
    run_phase(150);
    load_geometry(1023, 1023, 1023, 1023, 7);
    run_phase(120);
    load_geometry(13, 9, 13, 9, 1);
    quiet = 1'b1;
    run_phase(150);
    in_push <= 1'b0;

    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("box_filter_resampler_unit_tb: PASS");
    end else begin
      $display("box_filter_resampler_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== box_filter_resampler_unit.f =====
design/bfr_pkg.sv
design/bfr_div.sv
design/bfr_queue.sv
design/bfr_front.sv
design/bfr_back.sv
design/box_filter_resampler_unit.sv
bench/box_filter_resampler_unit_tb.sv
